FILE: sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define TLJ_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("assertion failed");

// checked at every edge, reset included
`define TLJ_ASSERT_ALWAYS(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) prop) \
        else $error("assertion failed");

`endif

FILE: sv/tlj_pkg.sv
// package with widths, types and state codes of the line justifier
package tlj_pkg;

    localparam int MAX_WIDTH      = 64;
    localparam int MAX_LINE_WORDS = 32;

    localparam int LEN_W      = 7;
    localparam int SP_W       = 6;
    localparam int CNT_W      = $clog2(MAX_LINE_WORDS + 1);
    localparam int ADDR_W     = $clog2(MAX_LINE_WORDS);
    localparam int DIVIDEND_W = LEN_W;
    localparam int DIVISOR_W  = ADDR_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV    = 6'b000010,
        S_RD     = 6'b000100,
        S_LOAD   = 6'b001000,
        S_APPEND = 6'b010000,
        S_CHK    = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        PH_PRE  = 3'b001,
        PH_FILL = 3'b010,
        PH_LAST = 3'b100
    } phase_t;

endpackage

FILE: sv/tlj_ram.sv
// generic single-port-write ram with registered read
module tlj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/tlj_div.sv
// iterative restoring divider, one quotient bit per cycle
module tlj_div
    import tlj_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output div_status_t           status,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

FILE: sv/text_line_justifier.sv
// top level of the greedy full-justification line packer
//
// input channel: in_valid / in_stall with word_length and final_word; one
// word per request. output channel: out_valid / out_stall with one request
// per placed word (out_word_length, spaces_after, line_end, run_last).
// cfg_wr_en / cfg_wr_data write line_width; write only while idle.
// a word is taken only in the idle state; in_stall is high while a word is
// being placed or a line is being sent out.
// a word that closes no line passes through the append and check states
// before the block is back in idle; no new word is taken until then.
// a line of n words is sent by a walk over the word memory, a read and
// then a load of the output register for each word, after a run of the
// gap divider when n > 1 and the line is fully justified. run_last marks
// the last request caused by one word.
// a stalled output holds its request; the line walk waits at the load step
// until the output register is free.
// reset sets line_width to 64 and empties the open line; the word memory
// needs no clearing, only entries of the open line are read.
module text_line_justifier
    import tlj_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [LEN_W-1:0] word_length,
    input  logic             final_word,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [LEN_W-1:0] out_word_length,
    output logic [SP_W-1:0]  spaces_after,
    output logic             line_end,
    output logic             run_last
);

`include "assert_macros.svh"

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  pend_reg, pend_next;
    logic [LEN_W-1:0]  chars_reg, chars_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0]  lw_reg, lw_next;
    logic [LEN_W-1:0]  w_reg, w_next;
    logic              fin_reg, fin_next;

    logic              out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic [SP_W-1:0]   out_sp_reg, out_sp_next;
    logic              out_end_reg, out_end_next;
    logic              out_last_reg, out_last_next;

    logic [LEN_W-1:0]  lw_eff;
    logic [LEN_W-1:0]  in_len_sat;
    logic [LEN_W:0]    fit_sum;
    logic              emit_pre;
    logic [LEN_W-1:0]  pad;
    logic [ADDR_W-1:0] gaps;
    logic [LEN_W:0]    div_sum;
    logic              begin_emit;
    phase_t            begin_phase;
    logic              emit_last;
    logic              last_word;
    logic              out_free;
    logic [LEN_W-1:0]  sp_full;
    logic [LEN_W:0]    append_sum;

    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [LEN_W-1:0]  ram_rd_data;

    logic                  div_start;
    div_status_t           div_st;
    logic [DIVIDEND_W-1:0] div_q;
    logic [DIVISOR_W-1:0]  div_r;

    // effective width and saturated word length
    always_comb
    begin
        priority if (lw_reg == '0)
            lw_eff = LEN_W'(1);
        else if (lw_reg > LEN_W'(MAX_WIDTH))
            lw_eff = LEN_W'(MAX_WIDTH);
        else
            lw_eff = lw_reg;

        priority if (word_length == '0)
            in_len_sat = LEN_W'(1);
        else if (word_length > lw_eff)
            in_len_sat = lw_eff;
        else
            in_len_sat = word_length;
    end

    assign fit_sum  = {1'b0, chars_reg} + (LEN_W+1)'(1) + {1'b0, in_len_sat};
    assign emit_pre = (pend_reg != '0)
                   && ((pend_reg == CNT_W'(MAX_LINE_WORDS)) || (fit_sum > {1'b0, lw_eff}));

    assign pad     = (lw_eff > chars_reg) ? (lw_eff - chars_reg) : '0;
    assign gaps    = ADDR_W'(pend_reg - CNT_W'(1));
    assign div_sum = (LEN_W+1)'(gaps) + {1'b0, pad};

    assign emit_last  = (phase_reg == PH_LAST);
    assign last_word  = ((CNT_W'(idx_reg) + CNT_W'(1)) == pend_reg);
    assign out_free   = !out_valid_reg || !out_stall;
    assign append_sum = (pend_reg != '0)
                      ? ({1'b0, chars_reg} + (LEN_W+1)'(1) + {1'b0, w_reg})
                      : {1'b0, w_reg};

    // spaces after the word at idx_reg
    always_comb
    begin
        priority if (last_word)
            sp_full = (emit_last || (pend_reg == CNT_W'(1))) ? pad : '0;
        else if (emit_last)
            sp_full = LEN_W'(1);
        else
            sp_full = div_q + LEN_W'(idx_reg < div_r);
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        pend_next      = pend_reg;
        chars_next     = chars_reg;
        idx_next       = idx_reg;
        lw_next        = lw_reg;
        w_next         = w_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_len_next   = out_len_reg;
        out_sp_next    = out_sp_reg;
        out_end_next   = out_end_reg;
        out_last_next  = out_last_reg;
        begin_emit     = 1'b0;
        begin_phase    = PH_PRE;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        div_start      = 1'b0;

        if (cfg_wr_en)
        begin
            lw_next = cfg_wr_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    w_next   = in_len_sat;
                    fin_next = final_word;
                    if (emit_pre)
                    begin
                        begin_emit  = 1'b1;
                        begin_phase = PH_PRE;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_DIV:
            begin
                if (div_st.done)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = ram_rd_data;
                    out_sp_next    = sp_full[SP_W-1:0];
                    out_end_next   = last_word;
                    out_last_next  = last_word
                        && !((phase_reg == PH_PRE) && ((w_reg >= lw_eff) || fin_reg));
                    if (last_word)
                    begin
                        pend_next  = '0;
                        chars_next = '0;
                        state_next = (phase_reg == PH_PRE) ? S_APPEND : S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_APPEND:
            begin
                ram_wr_en  = 1'b1;
                chars_next = append_sum[LEN_W-1:0];
                pend_next  = pend_reg + CNT_W'(1);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                priority if (chars_reg >= lw_eff)
                begin
                    begin_emit  = 1'b1;
                    begin_phase = PH_FILL;
                end
                else if (fin_reg)
                begin
                    begin_emit  = 1'b1;
                    begin_phase = PH_LAST;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (begin_emit)
        begin
            phase_next = begin_phase;
            idx_next   = '0;
            if ((begin_phase != PH_LAST) && (pend_reg > CNT_W'(1)))
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            else
            begin
                state_next = S_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_PRE;
            pend_reg      <= '0;
            chars_reg     <= '0;
            idx_reg       <= '0;
            lw_reg        <= LEN_W'(MAX_WIDTH);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pend_reg      <= pend_next;
            chars_reg     <= chars_next;
            idx_reg       <= idx_next;
            lw_reg        <= lw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        fin_reg      <= fin_next;
        out_len_reg  <= out_len_next;
        out_sp_reg   <= out_sp_next;
        out_end_reg  <= out_end_next;
        out_last_reg <= out_last_next;
    end

    tlj_ram #(
        .WIDTH(LEN_W),
        .DEPTH(MAX_LINE_WORDS)
    ) u_words (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(pend_reg[ADDR_W-1:0]),
        .wr_data(w_reg),
        .rd_en  (ram_rd_en),
        .rd_addr(idx_reg),
        .rd_data(ram_rd_data)
    );

    tlj_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_sum[DIVIDEND_W-1:0]),
        .divisor  (gaps),
        .status   (div_st),
        .quotient (div_q),
        .remainder(div_r)
    );

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign out_word_length = out_len_reg;
    assign spaces_after    = out_sp_reg;
    assign line_end        = out_end_reg;
    assign run_last        = out_last_reg;

    `TLJ_ASSERT_ALWAYS(a_pend_bound, clk, pend_reg <= CNT_W'(MAX_LINE_WORDS))
    `TLJ_ASSERT(a_append_room, clk, rst_n,
        (state_reg == S_APPEND) |-> (pend_reg < CNT_W'(MAX_LINE_WORDS)))
    `TLJ_ASSERT(a_load_shows, clk, rst_n,
        ((state_reg == S_LOAD) && out_free) |=> out_valid_reg)
    `TLJ_ASSERT(a_div_active, clk, rst_n,
        (state_reg == S_DIV) |-> (div_st.busy || div_st.done))
    `TLJ_ASSERT(a_walk_nonempty, clk, rst_n,
        ((state_reg == S_RD) || (state_reg == S_LOAD)) |-> (pend_reg != '0))

endmodule

FILE: sim/testbench.sv
// self-checking testbench of the greedy line justifier, with scoreboard and drivers
module testbench
    import tlj_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 10;
    localparam int END_CYCLES    = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 22;
    localparam int SHOWN_ERRORS  = 40;

    typedef struct {
        logic [LEN_W-1:0] len;
        logic [SP_W-1:0]  spaces;
        logic             eol;
        logic             item_done;
    } placed_word_t;

    class line_justify_scoreboard;
        logic [LEN_W-1:0] width_reg;
        int unsigned      line_words[MAX_LINE_WORDS];
        int unsigned      word_count;
        int unsigned      chars_taken;
        placed_word_t     expected_words[$];
        int unsigned      errors;
        int unsigned      words_noted;
        int unsigned      words_checked;
        int unsigned      width_writes;

        function new();
            width_reg     = LEN_W'(MAX_WIDTH);
            word_count    = 0;
            chars_taken   = 0;
            errors        = 0;
            words_noted   = 0;
            words_checked = 0;
            width_writes  = 0;
        endfunction

        function void set_width(logic [LEN_W-1:0] v);
            width_reg = v;
            width_writes++;
        endfunction

        function int unsigned usable_width();
            if (width_reg < 1)
                return 1;
            if (width_reg > MAX_WIDTH)
                return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned outstanding();
            return expected_words.size();
        endfunction

        function void flush_line(int unsigned lw, bit final_line);
            int unsigned  n;
            int unsigned  pad;
            int unsigned  gaps;
            int unsigned  total;
            int unsigned  sp;
            placed_word_t r;
            n   = word_count;
            pad = (lw > chars_taken) ? lw - chars_taken : 0;
            for (int unsigned i = 0; i < n; i++)
            begin
                if (i == n - 1)
                    sp = (final_line || n == 1) ? pad : 0;
                else if (final_line)
                    sp = 1;
                else
                begin
                    gaps  = n - 1;
                    total = gaps + pad;
                    sp    = total / gaps + ((i < total % gaps) ? 1 : 0);
                end
                r.len       = line_words[i][LEN_W-1:0];
                r.spaces    = sp[SP_W-1:0];
                r.eol       = (i == n - 1);
                r.item_done = 1'b0;
                expected_words = {expected_words, r};
            end
            word_count  = 0;
            chars_taken = 0;
        endfunction

        function void note_word(logic [LEN_W-1:0] len, logic fin);
            int unsigned  lw;
            int unsigned  w;
            int unsigned  first;
            lw = usable_width();
            w  = len;
            if (w < 1)
                w = 1;
            if (w > lw)
                w = lw;
            first = expected_words.size();
            words_noted++;
            if (word_count > 0 && (word_count >= MAX_LINE_WORDS || chars_taken + 1 + w > lw))
                flush_line(lw, 1'b0);
            if (word_count < MAX_LINE_WORDS)
            begin
                chars_taken += (word_count > 0) ? 1 + w : w;
                line_words[word_count] = w;
                word_count++;
            end
            if (chars_taken >= lw)
                flush_line(lw, 1'b0);
            if (fin && word_count > 0)
                flush_line(lw, 1'b1);
            if (expected_words.size() > first)
                expected_words[expected_words.size() - 1].item_done = 1'b1;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_word(placed_word_t got);
            placed_word_t want;
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("%0t: unexpected placed word, expected none, actual length %0d",
                             $time, got.len);
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            compare_field("out_word_length", want.len, got.len);
            compare_field("spaces_after", want.spaces, got.spaces);
            compare_field("line_end", want.eol, got.eol);
            compare_field("run_last", want.item_done, got.item_done);
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [LEN_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_stall;
    logic [LEN_W-1:0] word_length;
    logic             final_word;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [LEN_W-1:0] out_word_length;
    logic [SP_W-1:0]  spaces_after;
    logic             line_end;
    logic             run_last;

    logic             long_hold = 1'b0;
    int               rx_idle_pct = 75;
    int               tx_idle_pct = 25;
    int               cycle_count = 0;
    event             hold_go;

    line_justify_scoreboard sb;

    text_line_justifier dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .word_length     (word_length),
        .final_word      (final_word),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_word_length (out_word_length),
        .spaces_after    (spaces_after),
        .line_end        (line_end),
        .run_last        (run_last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: check accepted requests, then pick the next stall
    always @(posedge clk)
    begin
        placed_word_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.len       = out_word_length;
            got.spaces    = spaces_after;
            got.eol       = line_end;
            got.item_done = run_last;
            sb.check_word(got);
        end
        out_stall <= long_hold || ($urandom_range(99) < rx_idle_pct);
    end

    // long receiver hold-off
    initial
    begin
        forever
        begin
            @(hold_go);
            long_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            long_hold <= 1'b0;
        end
    end

    function automatic logic [LEN_W-1:0] pick_length(int unsigned lw);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 10)
            return LEN_W'($urandom_range(127, lw));
        if (r < 60)
            return LEN_W'($urandom_range(lw < 8 ? lw : 8, 1));
        return LEN_W'($urandom_range(lw, 1));
    endfunction

    task automatic send_word(input logic [LEN_W-1:0] len, input logic fin);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_length <= len;
        final_word  <= fin;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(len, fin);
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input logic [LEN_W-1:0] v);
        settle_block();
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_width(v);
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] width, input int unsigned budget);
        int unsigned sent;
        int unsigned n;
        int unsigned lw;
        int unsigned kind;
        write_width(width);
        lw   = sb.usable_width();
        sent = 0;
        // one line long enough to fill the word buffer
        if (lw == MAX_WIDTH)
        begin
            n = MAX_LINE_WORDS + 1 + $urandom_range(6);
            for (int unsigned i = 0; i < n; i++)
                send_word(LEN_W'($urandom_range(1)), i == n - 1);
            sent += n;
        end
        while (sent < budget)
        begin
            kind = $urandom_range(99);
            n    = $urandom_range(kind < 85 ? 12 : 5, 1);
            for (int unsigned i = 0; i < n; i++)
                if (kind < 85)
                    send_word(pick_length(lw), i == n - 1);
                else
                    send_word(LEN_W'($urandom_range(127, 0)), 1'($urandom_range(1)));
            sent += n;
        end
    endtask

    initial
    begin
        logic [LEN_W-1:0] phase_widths[PHASES];
        phase_widths = '{7'd16, 7'd1, 7'd64, 7'd7, 7'd127, 7'd0, 7'd33, 7'd65, 7'd0};
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        word_length = '0;
        final_word  = 1'b0;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset width, exact fills, saturation, zero length
        send_word(7'd64, 1'b0);
        send_word(7'd127, 1'b0);
        send_word(7'd0, 1'b0);
        send_word(7'd30, 1'b0);
        send_word(7'd31, 1'b0);
        send_word(7'd40, 1'b0);
        send_word(7'd30, 1'b0);
        send_word(7'd20, 1'b0);
        send_word(7'd5, 1'b1);
        send_word(7'd60, 1'b0);
        send_word(7'd3, 1'b1);
        send_word(7'd10, 1'b1);
        send_word(7'd10, 1'b0);
        send_word(7'd10, 1'b0);
        send_word(7'd10, 1'b0);
        send_word(7'd40, 1'b0);
        send_word(7'd3, 1'b0);
        // width shrunk below the open line
        write_width(7'd20);
        send_word(7'd7, 1'b0);
        send_word(7'd12, 1'b1);
        write_width(7'd0);
        send_word(7'd5, 1'b0);
        send_word(7'd0, 1'b1);
        write_width(7'd127);
        send_word(7'd127, 1'b1);
        write_width(7'd65);
        send_word(7'd1, 1'b0);
        send_word(7'd1, 1'b1);

        // receiver holds off while the sender keeps offering
        write_width(7'd12);
        tx_idle_pct = 0;
        -> hold_go;
        for (int i = 0; i < 40; i++)
            send_word(pick_length(12), i == 39);
        settle_block();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 3)
            begin
                tx_idle_pct = 25;
                rx_idle_pct <= 75;
            end
            else if (p < 6)
            begin
                tx_idle_pct = 75;
                rx_idle_pct <= 25;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            run_phase((p == PHASES - 1) ? LEN_W'($urandom_range(64, 1)) : phase_widths[p],
                      PHASE_ITEMS);
        end

        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);

        $display("%0d words sent under %0d line width settings, %0d placed words checked",
                 sb.words_noted, sb.width_writes + 1, sb.words_checked);
        $display("covered three idle mixes, a long output hold-off and a full word buffer");
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
